// ----- src/qvt_pkg.sv -----
// Shared types and codes of the quorum vote tracker.
`timescale 1ns / 1ps

package qvt_pkg;

  // Width of the slot number in a result word.
  localparam int SlotW = 3;
  // Width of the vote count in a result word.
  localparam int CountW = 4;

  // Input word mode codes.
  localparam logic [1:0] MODE_RECORD   = 2'd0;
  localparam logic [1:0] MODE_CLR_SLOT = 2'd1;
  localparam logic [1:0] MODE_CLR_ALL  = 2'd2;

  // Command broadcast to the row of slot cells.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WITHDRAW,
    OP_VOTE,
    OP_CLR_ONE,
    OP_CLR_ALL
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_VOTE,
    ST_COUNT,
    ST_DONE
  } state_e;

  // Priority chain passed from cell to cell, lowest slot first.
  typedef struct packed {
    logic             found;  // an earlier slot holds the sender's bit
    logic             hit;    // an earlier slot matches the tag
    logic             free;   // an earlier slot is free
    logic             dup;    // the chosen slot already had the sender's bit
    logic [SlotW-1:0] slot;   // number of the selected slot
  } chain_t;

  // One result word.
  typedef struct packed {
    logic              duplicate;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] vote_count;
    logic              majority;
    logic              table_full;
  } res_t;

endpackage

// ----- src/qvt_cell.sv -----
// One vote slot: tag, valid bit, voter bitmap and its link in the priority chain.
`timescale 1ns / 1ps

module qvt_cell #(
  parameter int MAX_REPLICAS = 8,
  parameter int TAG_WIDTH    = 32,
  parameter int IDX          = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qvt_pkg::op_e            op_i,
  input  logic                    active_i,
  input  logic                    clr_sel_i,
  input  logic [TAG_WIDTH-1:0]    tag_i,
  input  logic [MAX_REPLICAS-1:0] bit_i,
  input  logic [MAX_REPLICAS-1:0] mask_i,
  input  logic                    match_any_i,
  input  qvt_pkg::chain_t         chain_i,
  output qvt_pkg::chain_t         chain_o,
  input  logic [MAX_REPLICAS-1:0] acc_i,
  output logic [MAX_REPLICAS-1:0] acc_o
);

  logic                    valid_q, valid_d;
  logic                    sel_q, sel_d;
  logic [TAG_WIDTH-1:0]    tag_q, tag_d;
  logic [MAX_REPLICAS-1:0] bits_q, bits_d;
  logic [MAX_REPLICAS-1:0] rest;
  logic                    eq, has_bit, my_found, my_match, my_free, claim, dup_here;

  always_comb begin
    eq       = valid_q && (tag_q == tag_i);
    has_bit  = |(bits_q & bit_i);
    rest     = bits_q & ~bit_i;
    my_found = active_i && has_bit && !chain_i.found;
    my_match = active_i && eq && !chain_i.hit;
    my_free  = active_i && !valid_q && !chain_i.free;
    claim    = my_free && !match_any_i;

    case (op_i)
      qvt_pkg::OP_WITHDRAW: dup_here = my_found && eq;
      qvt_pkg::OP_VOTE:     dup_here = my_match && has_bit;
      default:              dup_here = 1'b0;
    endcase

    chain_o.found = chain_i.found | my_found;
    chain_o.hit   = chain_i.hit | my_match;
    chain_o.free  = chain_i.free | my_free;
    chain_o.dup   = chain_i.dup | dup_here;
    chain_o.slot  = sel_q ? qvt_pkg::SlotW'(IDX) : chain_i.slot;
    acc_o         = acc_i | (sel_q ? (bits_q & mask_i) : '0);
  end

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    tag_d   = tag_q;
    bits_d  = bits_q;
    case (op_i)
      qvt_pkg::OP_WITHDRAW: begin
        sel_d = my_found && eq;
        if (my_found && !eq) begin
          bits_d = rest;
          if ((rest & mask_i) == '0) begin
            valid_d = 1'b0;
            tag_d   = '0;
            bits_d  = '0;
          end
        end
      end
      qvt_pkg::OP_VOTE: begin
        sel_d = my_match || claim;
        if (my_match) begin
          bits_d = bits_q | bit_i;
        end else if (claim) begin
          valid_d = 1'b1;
          tag_d   = tag_i;
          bits_d  = bit_i;
        end
      end
      qvt_pkg::OP_CLR_ONE: begin
        if (clr_sel_i) begin
          valid_d = 1'b0;
          tag_d   = '0;
          bits_d  = '0;
        end
      end
      qvt_pkg::OP_CLR_ALL: begin
        valid_d = 1'b0;
        tag_d   = '0;
        bits_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
      bits_q  <= '0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

endmodule

// ----- src/quorum_vote_tracker_unit.sv -----
// Top level of the quorum vote tracker: sequencer, result register and the row of slot cells.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   mode_i, sender_i, tag_i, slot_select_i
//   out      output     out_valid_o / out_ready_i duplicate_o, slot_o, vote_count_o,
//                                                 majority_o, table_full_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (num_replicas)
//
// One word is worked on at a time. A vote passes through accept, withdraw pass, vote pass,
// count pass and hand-off; its result word is valid once the hand-off has loaded the output
// register. A vote that finds no matching and no free slot skips the count pass; clears,
// the unused mode and senders out of range hand off right after the first pass over the row.
// Reset empties every slot and sets num_replicas to 3.
// A stalled output holds the sequencer in its hand-off state; the input is not taken again
// until the previous word has moved into the output register.
`timescale 1ns / 1ps

module quorum_vote_tracker_unit #(
  parameter int MAX_REPLICAS = 8,
  parameter int TAG_WIDTH    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         sender_i,
  input  logic signed [31:0] tag_i,
  input  logic [2:0]         slot_select_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               duplicate_o,
  output logic [2:0]         slot_o,
  output logic [3:0]         vote_count_o,
  output logic               majority_o,
  output logic               table_full_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i
);

  // Width that holds the replica count itself.
  localparam int NW = $clog2(MAX_REPLICAS + 1);

  qvt_pkg::state_e         state_q, state_d;
  qvt_pkg::op_e            op;
  logic [3:0]              num_replicas_q;
  logic [NW-1:0]           n_act;
  logic [NW-1:0]           cnt;

  // Captured input word.
  logic [1:0]              mode_q;
  logic [2:0]              sender_q;
  logic [TAG_WIDTH-1:0]    tag_q;
  logic [2:0]              sel_q;

  logic                    dup_q, dup_d;
  qvt_pkg::res_t           res_q, res_d;
  qvt_pkg::res_t           out_q;
  logic                    out_valid_q;
  logic                    load_out;
  logic                    sender_ok;

  logic [MAX_REPLICAS-1:0] active, clr_sel, mask, bitv;
  qvt_pkg::chain_t         chain [MAX_REPLICAS+1];
  logic [MAX_REPLICAS-1:0] acc   [MAX_REPLICAS+1];
  qvt_pkg::chain_t         chain_end;

  // Clamp the replica count to 1..MAX_REPLICAS.
  always_comb begin
    if (num_replicas_q == '0) begin
      n_act = NW'(1);
    end else if (32'(num_replicas_q) > MAX_REPLICAS) begin
      n_act = NW'(MAX_REPLICAS);
    end else begin
      n_act = NW'(num_replicas_q);
    end
  end

  // Per-slot and per-bit broadcast lines; slot count and bitmap width are the same.
  always_comb begin
    for (int i = 0; i < MAX_REPLICAS; i++) begin
      active[i]  = 32'(n_act) > i;
      mask[i]    = 32'(n_act) > i;
      bitv[i]    = 32'(sender_q) == i;
      clr_sel[i] = 32'(sel_q) == i;
    end
  end

  assign sender_ok = 32'(sender_q) < 32'(n_act);

  // Row of slot cells; the priority chain enters at slot 0.
  assign chain[0] = '0;
  assign acc[0]   = '0;

  for (genvar g = 0; g < MAX_REPLICAS; g++) begin : g_cell
    qvt_cell #(
      .MAX_REPLICAS (MAX_REPLICAS),
      .TAG_WIDTH    (TAG_WIDTH),
      .IDX          (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .active_i    (active[g]),
      .clr_sel_i   (clr_sel[g]),
      .tag_i       (tag_q),
      .bit_i       (bitv),
      .mask_i      (mask),
      .match_any_i (chain_end.hit),
      .chain_i     (chain[g]),
      .chain_o     (chain[g+1]),
      .acc_i       (acc[g]),
      .acc_o       (acc[g+1])
    );
  end

  assign chain_end = chain[MAX_REPLICAS];
  assign cnt       = NW'($countones(acc[MAX_REPLICAS]));

  // Sequencer: clear or withdraw pass, vote pass, count pass, then hand the word to the output.
  always_comb begin
    state_d    = state_q;
    op         = qvt_pkg::OP_NONE;
    dup_d      = dup_q;
    res_d      = res_q;
    load_out   = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      qvt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = qvt_pkg::ST_EXEC;
        end
      end
      qvt_pkg::ST_EXEC: begin
        res_d   = '0;
        state_d = qvt_pkg::ST_DONE;
        case (mode_q)
          qvt_pkg::MODE_CLR_SLOT: begin
            op         = qvt_pkg::OP_CLR_ONE;
            res_d.slot = sel_q;
          end
          qvt_pkg::MODE_CLR_ALL: begin
            op = qvt_pkg::OP_CLR_ALL;
          end
          qvt_pkg::MODE_RECORD: begin
            // Drop a sender beyond the active replicas; otherwise pull its old vote.
            if (sender_ok) begin
              op      = qvt_pkg::OP_WITHDRAW;
              dup_d   = chain_end.dup;
              state_d = qvt_pkg::ST_VOTE;
            end
          end
          default: begin
          end
        endcase
      end
      qvt_pkg::ST_VOTE: begin
        if (dup_q) begin
          state_d = qvt_pkg::ST_COUNT;
        end else begin
          op = qvt_pkg::OP_VOTE;
          if (!chain_end.hit && !chain_end.free) begin
            // No match and no free slot: drop the vote.
            res_d.table_full = 1'b1;
            state_d          = qvt_pkg::ST_DONE;
          end else begin
            dup_d   = chain_end.dup;
            state_d = qvt_pkg::ST_COUNT;
          end
        end
      end
      qvt_pkg::ST_COUNT: begin
        res_d.duplicate  = dup_q;
        res_d.slot       = chain_end.slot;
        res_d.vote_count = qvt_pkg::CountW'(cnt);
        res_d.majority   = cnt > (n_act >> 1);
        res_d.table_full = 1'b0;
        state_d          = qvt_pkg::ST_DONE;
      end
      qvt_pkg::ST_DONE: begin
        // Hold until the output register is empty or being drained.
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = qvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= qvt_pkg::ST_IDLE;
      num_replicas_q <= 4'd3;
      out_valid_q    <= 1'b0;
      dup_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      dup_q   <= dup_d;
      if (cfg_valid_i) begin
        num_replicas_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: captured input word, working result, output word.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= mode_i;
      sender_q <= sender_i;
      tag_q    <= TAG_WIDTH'(tag_i);
      sel_q    <= slot_select_i;
    end
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign duplicate_o  = out_q.duplicate;
  assign slot_o       = out_q.slot;
  assign vote_count_o = out_q.vote_count;
  assign majority_o   = out_q.majority;
  assign table_full_o = out_q.table_full;

endmodule
